>>> design/hpc_pkg.sv
// ----------------------------------------------------------------------------
// hpc_pkg
// Shared types and constants for the hot-wire probe controller.
// ----------------------------------------------------------------------------
package hpc_pkg;

  // Signed accumulator width.
  localparam int unsigned SUM_WIDTH    = 32;
  localparam int unsigned CNT_WIDTH    = 32;
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned FUNC_WIDTH   = 2;
  localparam int unsigned STATE_WIDTH  = 3;
  localparam int unsigned MODE_WIDTH   = 3;
  localparam int unsigned LIMIT_WIDTH  = 15;
  localparam int unsigned REF_WIDTH    = 2;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 15;
  localparam int unsigned DIV_CNT_W    = $clog2(SUM_WIDTH + 1);

  localparam logic [MODE_WIDTH-1:0]  MODE_RESET  = MODE_WIDTH'(1);
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(31000);

  // Clamp bounds for the latched mean, as quotient magnitudes.
  localparam logic [SUM_WIDTH-1:0] AVG_POS_MAX = SUM_WIDTH'(32767);
  localparam logic [SUM_WIDTH-1:0] AVG_NEG_MAX = SUM_WIDTH'(32768);

  typedef enum logic [FUNC_WIDTH-1:0] {
    FUNC_POLL   = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_READ   = 2'd2
  } func_e;

  typedef enum logic [STATE_WIDTH-1:0] {
    ST_DISABLED  = 3'd0,
    ST_WAITING   = 3'd1,
    ST_ENABLED   = 3'd2,
    ST_SATURATED = 3'd3,
    ST_POWERFAIL = 3'd4
  } probe_state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONVERTER_MODE   = 1'b0,
    CFG_SATURATION_LIMIT = 1'b1
  } cfg_idx_e;

  // Converter mode codes.
  localparam logic [MODE_WIDTH-1:0] MODE_G1_2V56  = 3'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_G1_1V1   = 3'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_G10_3V0  = 3'd2;
  localparam logic [MODE_WIDTH-1:0] MODE_G10_2V56 = 3'd3;
  localparam logic [MODE_WIDTH-1:0] MODE_G10_1V1  = 3'd4;

  typedef enum logic [REF_WIDTH-1:0] {
    REF_1V1  = 2'd0,
    REF_2V56 = 2'd1,
    REF_3V0  = 2'd2
  } ref_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic gain_ten;
    ref_e ref_sel;
  } conv_dec_t;

  function automatic conv_dec_t decode_mode(input logic [MODE_WIDTH-1:0] mode);
    conv_dec_t d;
    case (mode)
      MODE_G1_1V1:   d = '{gain_ten: 1'b0, ref_sel: REF_1V1};
      MODE_G10_3V0:  d = '{gain_ten: 1'b1, ref_sel: REF_3V0};
      MODE_G10_2V56: d = '{gain_ten: 1'b1, ref_sel: REF_2V56};
      MODE_G10_1V1:  d = '{gain_ten: 1'b1, ref_sel: REF_1V1};
      default:       d = '{gain_ten: 1'b0, ref_sel: REF_2V56};
    endcase
    return d;
  endfunction

endpackage

>>> design/hpc_if.sv
// ----------------------------------------------------------------------------
// hpc interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface hpc_in_if;
  logic                                valid;
  logic                                ready;
  logic [hpc_pkg::FUNC_WIDTH-1:0]      func;
  logic                                battery_ok;
  logic                                probe_pin;
  logic signed [hpc_pkg::SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, func, battery_ok, probe_pin, sample, input ready);
  modport sink   (input valid, func, battery_ok, probe_pin, sample, output ready);
endinterface

interface hpc_out_if;
  logic                                valid;
  logic                                ready;
  logic [hpc_pkg::STATE_WIDTH-1:0]     probe_state;
  logic signed [hpc_pkg::SAMPLE_WIDTH-1:0] average;
  logic                                sampling_on;
  logic                                pullup_on;
  logic                                gain_ten;
  logic [hpc_pkg::REF_WIDTH-1:0]       reference_code;

  modport source (output valid, probe_state, average, sampling_on, pullup_on, gain_ten,
                  reference_code, input ready);
  modport sink   (input valid, probe_state, average, sampling_on, pullup_on, gain_ten,
                  reference_code, output ready);
endinterface

interface hpc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hpc_pkg::CFG_IDX_W-1:0]   index;
  logic [hpc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/hpc_div.sv
// ----------------------------------------------------------------------------
// hpc_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module hpc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [hpc_pkg::SUM_WIDTH-1:0]     dividend_i,
  input  logic [hpc_pkg::CNT_WIDTH-1:0]     divisor_i,
  output hpc_pkg::div_stat_t                stat_o,
  output logic [hpc_pkg::SUM_WIDTH-1:0]     quotient_o
);

  localparam int unsigned SW = hpc_pkg::SUM_WIDTH;
  localparam int unsigned CW = hpc_pkg::CNT_WIDTH;
  localparam int unsigned KW = hpc_pkg::DIV_CNT_W;
  localparam logic [KW-1:0] LAST_STEP = KW'(SW - 1);

  typedef enum logic {
    DS_IDLE,
    DS_RUN
  } div_state_e;

  div_state_e     st_q;
  logic [KW-1:0]  step_q;
  logic [CW-1:0]  rem_q;
  logic [CW-1:0]  dvs_q;
  logic [SW-1:0]  quo_q;
  logic           done_q;

  logic [CW:0]    shifted;
  logic [CW+1:0]  diff;
  logic           ge;

  // Quotient register also holds the dividend bits not yet consumed.
  assign shifted = {rem_q, quo_q[SW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~diff[CW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= DS_IDLE;
      step_q <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        DS_IDLE: begin
          if (start_i) begin
            rem_q  <= '0;
            dvs_q  <= divisor_i;
            quo_q  <= dividend_i;
            step_q <= '0;
            st_q   <= DS_RUN;
          end
        end
        DS_RUN: begin
          rem_q  <= ge ? diff[CW-1:0] : shifted[CW-1:0];
          quo_q  <= {quo_q[SW-2:0], ge};
          step_q <= step_q + KW'(1);
          if (step_q == LAST_STEP) begin
            done_q <= 1'b1;
            st_q   <= DS_IDLE;
          end
        end
        default: st_q <= DS_IDLE;
      endcase
    end
  end

  assign stat_o.busy = (st_q == DS_RUN);
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

>>> design/hotwire_probe_controller.sv
// ----------------------------------------------------------------------------
// hotwire_probe_controller
// Hot-wire probe supervisor: state tracking, sample averaging, saturation.
// ----------------------------------------------------------------------------
// Each input transfer yields exactly one result transfer showing the probe
// state after the item. Items that need no divide go from the idle state to
// the emit state, which loads the result register and returns to idle.
// A read with samples pending, and a poll in the enabled state with a good
// battery and a positive sum, run the shared restoring divider (sum magnitude
// / count, one quotient bit per clock); the block waits in the divide state
// until the divider is done and then passes through the emit state. The
// input is not ready while an item is in work; the result sits in an output
// register, so a stalled sink only holds the block at the point of emitting
// the next result.
// Register writes are taken any cycle and should be issued while idle.
// ----------------------------------------------------------------------------
module hotwire_probe_controller (
  input  logic            clk_i,
  input  logic            rst_ni,
  hpc_in_if.sink          in_i,
  hpc_out_if.source       out_o,
  hpc_cfg_if.sink         cfg_i
);

  localparam int unsigned SW = hpc_pkg::SUM_WIDTH;
  localparam int unsigned CW = hpc_pkg::CNT_WIDTH;
  localparam int unsigned XW = hpc_pkg::SAMPLE_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } ctl_state_e;

  // Control and architectural state
  ctl_state_e                         st_q;
  hpc_pkg::probe_state_e              mode_q;
  logic signed [SW-1:0]               sum_q;
  logic [CW-1:0]                      cnt_q;
  logic signed [XW-1:0]               avg_q;
  logic [hpc_pkg::MODE_WIDTH-1:0]     conv_mode_q;
  logic [hpc_pkg::LIMIT_WIDTH-1:0]    limit_q;
  logic                               op_read_q;  // divide serves a read, else a poll
  logic                               neg_q;      // sign of the dividend

  // Result register
  logic                               out_valid_q;
  hpc_pkg::probe_state_e              out_state_q;
  logic signed [XW-1:0]               out_avg_q;
  hpc_pkg::conv_dec_t                 out_dec_q;

  // Item decode
  logic                   in_xfer;
  logic                   cfg_xfer;
  hpc_pkg::func_e         func;
  logic                   cnt_zero;
  logic                   cnt_full;
  logic                   sum_pos;
  logic                   div_start;
  logic [SW-1:0]          sum_mag;

  // Saturating accumulate
  logic signed [SW:0]     sum_ext;
  logic signed [SW-1:0]   sum_sat;

  // Divider
  hpc_pkg::div_stat_t     div_stat;
  logic [SW-1:0]          quo;
  logic signed [XW-1:0]   avg_clamped;
  logic                   over_limit;

  assign in_xfer  = in_i.valid & in_i.ready;
  assign cfg_xfer = cfg_i.valid & cfg_i.ready;
  assign func     = hpc_pkg::func_e'(in_i.func);

  assign in_i.ready  = (st_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign cnt_zero = (cnt_q == '0);
  assign cnt_full = (cnt_q == '1);
  assign sum_pos  = ~sum_q[SW-1] & (sum_q != '0);
  // Two's-complement magnitude; the most negative sum still fits unsigned.
  assign sum_mag  = sum_q[SW-1] ? (~sum_q + SW'(1)) : sum_q;

  // Divide on a read with samples pending, or on a poll that may saturate.
  // A non-positive mean can never exceed the (non-negative) limit.
  always_comb begin
    div_start = 1'b0;
    if (in_xfer) begin
      if (func == hpc_pkg::FUNC_READ) begin
        div_start = ~cnt_zero;
      end else if (func == hpc_pkg::FUNC_POLL) begin
        div_start = in_i.battery_ok & (mode_q == hpc_pkg::ST_ENABLED) &
                    ~cnt_zero & sum_pos;
      end
    end
  end

  // Sum saturates at the signed accumulator limits.
  assign sum_ext = {sum_q[SW-1], sum_q} + (SW+1)'(in_i.sample);
  always_comb begin
    if (sum_ext[SW] != sum_ext[SW-1]) begin
      sum_sat = sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SW-1:0];
    end
  end

  hpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (cnt_q),
    .stat_o     (div_stat),
    .quotient_o (quo)
  );

  // Mean clamped into the 16-bit signed result range.
  always_comb begin
    if (neg_q) begin
      avg_clamped = (quo > hpc_pkg::AVG_NEG_MAX) ? {1'b1, {(XW-1){1'b0}}}
                                                 : XW'(~quo + SW'(1));
    end else begin
      avg_clamped = (quo > hpc_pkg::AVG_POS_MAX) ? {1'b0, {(XW-1){1'b1}}} : quo[XW-1:0];
    end
  end
  assign over_limit = ~neg_q & (quo > SW'(limit_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      mode_q      <= hpc_pkg::ST_DISABLED;
      sum_q       <= '0;
      cnt_q       <= '0;
      avg_q       <= '0;
      conv_mode_q <= hpc_pkg::MODE_RESET;
      limit_q     <= hpc_pkg::LIMIT_RESET;
      op_read_q   <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_state_q <= hpc_pkg::ST_DISABLED;
      out_avg_q   <= '0;
      out_dec_q   <= '0;
    end else begin
      if (cfg_xfer) begin
        case (hpc_pkg::cfg_idx_e'(cfg_i.index))
          hpc_pkg::CFG_CONVERTER_MODE:   conv_mode_q <= cfg_i.data[hpc_pkg::MODE_WIDTH-1:0];
          hpc_pkg::CFG_SATURATION_LIMIT: limit_q     <= cfg_i.data;
          default: ;
        endcase
      end

      // the emit state owns the valid flag while it runs
      if (out_o.ready && (st_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      case (st_q)
        S_IDLE: begin
          if (in_xfer) begin
            op_read_q <= (func == hpc_pkg::FUNC_READ);
            neg_q     <= sum_q[SW-1];
            st_q      <= div_start ? S_DIV : S_EMIT;
            case (func)
              hpc_pkg::FUNC_POLL: begin
                if (!in_i.battery_ok) begin
                  // power fail falls straight through to waiting
                  mode_q <= hpc_pkg::ST_WAITING;
                end else begin
                  case (mode_q)
                    hpc_pkg::ST_WAITING: begin
                      if (!in_i.probe_pin) begin
                        mode_q <= hpc_pkg::ST_ENABLED;
                        sum_q  <= '0;
                        cnt_q  <= '0;
                      end
                    end
                    hpc_pkg::ST_ENABLED: ;  // saturation decided after the divide
                    hpc_pkg::ST_SATURATED: begin
                      if (in_i.probe_pin) begin
                        mode_q <= hpc_pkg::ST_WAITING;
                      end else begin
                        mode_q <= hpc_pkg::ST_ENABLED;
                        sum_q  <= '0;
                        cnt_q  <= '0;
                      end
                    end
                    default: mode_q <= hpc_pkg::ST_WAITING;
                  endcase
                end
              end
              hpc_pkg::FUNC_SAMPLE: begin
                if ((mode_q == hpc_pkg::ST_ENABLED) && !cnt_full) begin
                  sum_q <= sum_sat;
                  cnt_q <= cnt_q + CW'(1);
                end
              end
              default: ;  // a read with samples pending waits for the divider; code three does nothing
            endcase
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (op_read_q) begin
              avg_q <= avg_clamped;
              sum_q <= '0;
              cnt_q <= '0;
            end else if (over_limit) begin
              mode_q <= hpc_pkg::ST_SATURATED;
            end
            st_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_state_q <= mode_q;
            out_avg_q   <= avg_q;
            out_dec_q   <= hpc_pkg::decode_mode(conv_mode_q);
            st_q        <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.probe_state    = out_state_q;
  assign out_o.average        = out_avg_q;
  assign out_o.sampling_on    = (out_state_q == hpc_pkg::ST_ENABLED);
  assign out_o.pullup_on      = (out_state_q == hpc_pkg::ST_WAITING) ||
                                (out_state_q == hpc_pkg::ST_SATURATED);
  assign out_o.gain_ten       = out_dec_q.gain_ten;
  assign out_o.reference_code = out_dec_q.ref_sel;

`ifndef SYNTHESIS
  // Input is never taken while the divider is running.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !div_stat.busy)
    else $error("input ready while divider busy");

  // Divider completion only lands in the divide state.
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (st_q == S_DIV))
    else $error("divider done outside divide state");

  // An accepted item blocks the input for at least the next cycle.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_i.ready)
    else $error("input accepted twice in a row");

  // Reads clear the accumulator when the mean is latched.
  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV && div_stat.done && op_read_q) |=> (cnt_q == '0 && sum_q == '0))
    else $error("accumulator not cleared after read");
`endif

endmodule
